// ===== design/pointer_event_queue_top_assert.svh =====
// assertion macros for the pointer event queue checker
`ifndef POINTER_EVENT_QUEUE_TOP_ASSERT_SVH
`define POINTER_EVENT_QUEUE_TOP_ASSERT_SVH

// consequence must hold in the cycle after the trigger
`define PEQ_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("pointer event queue: next-cycle check failed");

// consequence must hold right after the second of two back-to-back triggers
`define PEQ_ASSERT_PAIR(label, clk, rst_n, trig_a, trig_b, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((trig_a) ##1 (trig_b)) |=> (cons)) \
        else $error("pointer event queue: sequence check failed");

`endif

// ===== design/peq_pkg.sv =====
// shared types and codes for the pointer event queue
package peq_pkg;

    // operation codes of an input item
    localparam logic OP_TRACK   = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // input item
    typedef struct packed {
        logic               operation;
        logic        [7:0]  buttons_in;
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
        logic               is_relative;
        logic        [31:0] stamp_in;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic        [7:0]  buttons_out;
        logic        [31:0] stamp_out;
        logic               available;
    } t_out_item;

endpackage

// ===== design/pointer_event_queue_top.sv =====
// pointer tracker with a ring of button-change snapshots
// an item is taken in every cycle (busy never rises); a consume gives its
// result in the cycle after acceptance, a track gives none
// saturating add and ring update run combinationally from the input into the position and ring registers
// synchronous active-low reset clears position, ring pointers and flags; ring contents stay
module pointer_event_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  peq_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_done,
    output peq_pkg::t_out_item o_result
);
    import peq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
    localparam logic signed [SW-1:0] C_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] C_LO = SW'(-(64'sd1 <<< (COORD_WIDTH - 1)));
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic        [7:0]             buttons;
        logic        [31:0]            stamp;
    } t_entry;

    // current pointer state and ring control
    t_entry          r_cur;
    t_entry          n_cur;
    logic [IW-1:0]   r_rd, n_rd;
    logic [IW-1:0]   r_wr, n_wr;
    logic            r_full, n_full;
    logic            r_news, n_news;
    logic            r_done;
    t_out_item       r_result;
    t_entry          r_queue [QUEUE_DEPTH];

    logic            w_accept;
    logic            w_track;
    logic            w_consume;
    logic            w_push;
    logic            w_pop;
    logic [IW-1:0]   w_wr_inc;
    logic [IW-1:0]   w_rd_inc;

    // new coordinate: optional relative add, then saturate to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] f_coord(
        input logic signed [15:0]            d,
        input logic signed [COORD_WIDTH-1:0] c,
        input logic                          rel
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] base;
        base = rel ? SW'(c) : '0;
        sum  = SW'(d) + base;
        if (sum > C_HI) begin
            sum = C_HI;
        end else if (sum < C_LO) begin
            sum = C_LO;
        end
        return COORD_WIDTH'(sum);
    endfunction

    // ring index advance with wrap
    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_track   = w_accept && (i_item.operation == OP_TRACK);
    assign w_consume = w_accept && (i_item.operation == OP_CONSUME);
    assign w_wr_inc  = f_inc(r_wr);
    assign w_rd_inc  = f_inc(r_rd);
    assign w_push    = w_track && !r_full && (r_cur.buttons != i_item.buttons_in);
    assign w_pop     = w_consume && r_news && (r_full || (r_rd != r_wr));

    // next state of position, pointers and flags
    always_comb begin
        n_cur  = r_cur;
        n_rd   = r_rd;
        n_wr   = r_wr;
        n_full = r_full;
        n_news = r_news;
        if (w_track) begin
            n_cur.x       = f_coord(i_item.x_in, r_cur.x, i_item.is_relative);
            n_cur.y       = f_coord(i_item.y_in, r_cur.y, i_item.is_relative);
            n_cur.buttons = i_item.buttons_in;
            n_cur.stamp   = i_item.stamp_in;
            n_news        = 1'b1;
            if (w_push) begin
                n_wr = w_wr_inc;
                if (w_wr_inc == r_rd) begin
                    n_full = 1'b1;
                end
            end
        end else if (w_consume && r_news) begin
            n_full = 1'b0;
            n_news = 1'b0;
            if (w_pop) begin
                n_rd = w_rd_inc;
            end
        end
    end

    // control and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_rd   <= '0;
            r_wr   <= '0;
            r_full <= 1'b0;
            r_news <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_full <= n_full;
            r_news <= n_news;
            r_done <= w_consume;
        end
    end

    // snapshot ring write
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr] <= n_cur;
        end
    end

    // result register: oldest snapshot or current state
    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            if (w_pop) begin
                r_result.x_out       <= 16'(r_queue[r_rd].x);
                r_result.y_out       <= 16'(r_queue[r_rd].y);
                r_result.buttons_out <= r_queue[r_rd].buttons;
                r_result.stamp_out   <= r_queue[r_rd].stamp;
            end else begin
                r_result.x_out       <= 16'(r_cur.x);
                r_result.y_out       <= 16'(r_cur.y);
                r_result.buttons_out <= r_cur.buttons;
                r_result.stamp_out   <= r_cur.stamp;
            end
            r_result.available <= r_news;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== design/peq_checker.sv =====
// port-level checks for the pointer event queue, bound to the top level
`include "pointer_event_queue_top_assert.svh"

module peq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input peq_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_done,
    input peq_pkg::t_out_item o_result
);
    import peq_pkg::*;

    logic w_take_track;
    logic w_take_consume;

    assign w_take_track   = start && !busy && (i_item.operation == OP_TRACK);
    assign w_take_consume = start && !busy && (i_item.operation == OP_CONSUME);

    // a consume item gives its result in the next cycle, anything else gives none
    `PEQ_ASSERT_NEXT(a_consume_done, i_clk, i_rst_n, w_take_consume, o_done)
    `PEQ_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !w_take_consume, !o_done)

    // a track item right before a consume makes it report news
    `PEQ_ASSERT_PAIR(a_track_sets_news, i_clk, i_rst_n, w_take_track, w_take_consume,
        o_result.available)

    // two consumes in a row: the second has nothing new
    `PEQ_ASSERT_PAIR(a_consume_clears_news, i_clk, i_rst_n, w_take_consume, w_take_consume,
        !o_result.available)

endmodule

bind pointer_event_queue_top peq_checker u_peq_checker (.*);
